@@ src/wat_pkg.sv @@
// wat_pkg: shared types and constants for the window acknowledgement tracker
// depends on nothing; used by every module of the tracker

package wat_pkg;

    localparam int WINDOW       = 5;
    localparam int NUM_W        = 31;
    localparam int REM_W        = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SLOT_W       = $clog2(WINDOW + 1);
    localparam int SLOT_FIELD_W = 3;
    localparam int NIBBLE_STEPS = (NUM_W + 3) / 4;
    localparam int PAD_W        = NIBBLE_STEPS * 4;
    localparam int STEP_CNT_W   = (NIBBLE_STEPS > 1) ? $clog2(NIBBLE_STEPS) : 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WINDOW-1:0] FULL_MASK = '1;
    localparam logic [REM_W-1:0]  LAST_POS  = REM_W'(WINDOW - 1);

    typedef enum logic {
        KIND_ACK     = 1'b0,
        KIND_TIMEOUT = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        EV_ACCEPT    = 2'd0,
        EV_DUPLICATE = 2'd1,
        EV_RESEND    = 2'd2,
        EV_COMPLETE  = 2'd3
    } event_t;

    typedef struct packed {
        kind_t              kind;
        logic [NUM_W-1:0]   num;
        logic [REM_W-1:0]   rem;
    } entry_t;

    function automatic logic [SLOT_FIELD_W-1:0] to_slot_field(input logic [SLOT_W-1:0] v);
        logic [SLOT_W+SLOT_FIELD_W-1:0] wide;
        wide = {{SLOT_FIELD_W{1'b0}}, v};
        return wide[SLOT_FIELD_W-1:0];
    endfunction

endpackage

@@ src/wat_queue.sv @@
// wat_queue: short fifo of classified words between front and back
// depends on wat_pkg

module wat_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  wat_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output wat_pkg::entry_t pop_data,
    output logic            empty
);

    wat_pkg::entry_t                 mem [wat_pkg::QUEUE_DEPTH];
    logic [wat_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [wat_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [wat_pkg::QCNT_W-1:0]      count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign full     = (count_reg == wat_pkg::QCNT_W'(wat_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == wat_pkg::QPTR_W'(wat_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == wat_pkg::QPTR_W'(wat_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ src/wat_front.sv @@
// wat_front: accepts input words and works out the window remainder
// of each acknowledgement, four bits a cycle; depends on wat_pkg

module wat_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  wat_pkg::kind_t             in_kind,
    input  logic [wat_pkg::NUM_W-1:0]  in_num,
    output logic                       push,
    output wat_pkg::entry_t            push_data,
    input  logic                       full
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    front_state_t                       st_reg;
    wat_pkg::kind_t                     kind_reg;
    logic [wat_pkg::NUM_W-1:0]          num_reg;
    logic [wat_pkg::PAD_W-1:0]          sh_reg;
    logic [wat_pkg::REM_W-1:0]          rem_reg;
    logic [wat_pkg::REM_W-1:0]          rem_next;
    logic [wat_pkg::STEP_CNT_W-1:0]     cnt_reg;

    // one nibble of remainder, msb first
    always_comb begin
        logic [wat_pkg::REM_W:0]   wide;
        logic [wat_pkg::REM_W-1:0] r;
        logic [3:0]                nib;
        r   = rem_reg;
        nib = sh_reg[wat_pkg::PAD_W-1 -: 4];
        for (int k = 3; k >= 0; k--) begin
            wide = {r, nib[k]};
            if (wide >= (wat_pkg::REM_W + 1)'(wat_pkg::WINDOW)) begin
                wide = wide - (wat_pkg::REM_W + 1)'(wat_pkg::WINDOW);
            end
            r = wide[wat_pkg::REM_W-1:0];
        end
        rem_next = r;
    end

    assign in_ready       = (st_reg == F_IDLE);
    assign push           = (st_reg == F_PUSH);
    assign push_data.kind = kind_reg;
    assign push_data.num  = num_reg;
    assign push_data.rem  = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= F_IDLE;
        end else begin
            unique case (st_reg)
                F_IDLE: begin
                    if (in_valid) begin
                        kind_reg <= in_kind;
                        num_reg  <= in_num;
                        sh_reg   <= wat_pkg::PAD_W'(in_num);
                        rem_reg  <= '0;
                        cnt_reg  <= '0;
                        st_reg   <= (in_kind == wat_pkg::KIND_ACK) ? F_DIV : F_PUSH;
                    end
                end
                F_DIV: begin
                    rem_reg <= rem_next;
                    sh_reg  <= sh_reg << 4;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == wat_pkg::STEP_CNT_W'(wat_pkg::NIBBLE_STEPS - 1)) begin
                        st_reg <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!full) begin
                        st_reg <= F_IDLE;
                    end
                end
                default: begin
                    st_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/wat_back.sv @@
// wat_back: slot state, duplicate check, window completion and resend scan
// drives the result register; depends on wat_pkg

module wat_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            empty,
    input  wat_pkg::entry_t pop_data,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [39:0]     m_tdata,
    output logic            m_tlast
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_CHECK,
        B_DONE,
        B_SCAN
    } back_state_t;

    back_state_t                            st_reg;
    logic [wat_pkg::NUM_W-1:0]              num_reg;
    logic [wat_pkg::REM_W-1:0]              rem_reg;
    logic [wat_pkg::REM_W-1:0]              pos_reg;
    logic [wat_pkg::WINDOW-1:0]             marks_reg;
    logic [wat_pkg::NUM_W-1:0]              base_reg;
    logic [wat_pkg::NUM_W-1:0]              last_acked_reg [wat_pkg::WINDOW];

    logic                                   m_valid_reg;
    wat_pkg::event_t                        ev_reg;
    logic [wat_pkg::SLOT_FIELD_W-1:0]       slot_reg;
    logic [wat_pkg::NUM_W-1:0]              pkt_reg;
    logic                                   last_reg;

    logic                                   out_free;
    logic                                   out_load;
    logic                                   dup;
    logic [wat_pkg::SLOT_W-1:0]             ack_slot;
    logic [wat_pkg::REM_W-1:0]              mark_idx;
    logic [wat_pkg::WINDOW-1:0]             marks_next;
    logic                                   higher_open;
    logic [wat_pkg::SLOT_W-1:0]             scan_slot;
    logic [wat_pkg::NUM_W-1:0]              base_next;

    assign out_free  = !m_valid_reg || m_tready;
    assign out_load  = out_free && ((st_reg == B_CHECK) || (st_reg == B_DONE) ||
                                    ((st_reg == B_SCAN) && !marks_reg[pos_reg]));
    assign pop       = (st_reg == B_IDLE) && !empty;
    assign dup       = (last_acked_reg[rem_reg] >= num_reg);
    assign ack_slot  = (rem_reg == '0) ? wat_pkg::SLOT_W'(wat_pkg::WINDOW)
                                       : wat_pkg::SLOT_W'(rem_reg);
    assign mark_idx  = (rem_reg == '0) ? wat_pkg::LAST_POS : rem_reg - 1'b1;
    assign scan_slot = wat_pkg::SLOT_W'(pos_reg) + 1'b1;
    assign base_next = base_reg + wat_pkg::NUM_W'(wat_pkg::WINDOW);

    always_comb begin
        for (int i = 0; i < wat_pkg::WINDOW; i++) begin
            marks_next[i] = marks_reg[i] || (mark_idx == wat_pkg::REM_W'(i));
        end
    end

    // any unmarked slot beyond the scan position
    always_comb begin
        higher_open = 1'b0;
        for (int i = 0; i < wat_pkg::WINDOW; i++) begin
            if ((wat_pkg::REM_W'(i) > pos_reg) && !marks_reg[i]) begin
                higher_open = 1'b1;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, pkt_reg, slot_reg, ev_reg};
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= B_IDLE;
            m_valid_reg <= 1'b0;
            marks_reg   <= '0;
            base_reg    <= '0;
            for (int i = 0; i < wat_pkg::WINDOW; i++) begin
                last_acked_reg[i] <= '0;
            end
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (st_reg)
                B_IDLE: begin
                    if (!empty) begin
                        num_reg <= pop_data.num;
                        rem_reg <= pop_data.rem;
                        pos_reg <= '0;
                        st_reg  <= (pop_data.kind == wat_pkg::KIND_ACK) ? B_CHECK : B_SCAN;
                    end
                end
                B_CHECK: begin
                    if (out_free) begin
                        slot_reg    <= wat_pkg::to_slot_field(ack_slot);
                        pkt_reg     <= num_reg;
                        if (dup) begin
                            ev_reg   <= wat_pkg::EV_DUPLICATE;
                            last_reg <= 1'b1;
                            st_reg   <= B_IDLE;
                        end else begin
                            ev_reg                  <= wat_pkg::EV_ACCEPT;
                            last_acked_reg[rem_reg] <= num_reg;
                            if (marks_next == wat_pkg::FULL_MASK) begin
                                marks_reg <= '0;
                                base_reg  <= base_next;
                                last_reg  <= 1'b0;
                                st_reg    <= B_DONE;
                            end else begin
                                marks_reg <= marks_next;
                                last_reg  <= 1'b1;
                                st_reg    <= B_IDLE;
                            end
                        end
                    end
                end
                B_DONE: begin
                    if (out_free) begin
                        ev_reg      <= wat_pkg::EV_COMPLETE;
                        slot_reg    <= '0;
                        pkt_reg     <= base_reg;
                        last_reg    <= 1'b1;
                        st_reg      <= B_IDLE;
                    end
                end
                B_SCAN: begin
                    if (marks_reg[pos_reg]) begin
                        if (pos_reg == wat_pkg::LAST_POS) begin
                            st_reg <= B_IDLE;
                        end else begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end else if (out_free) begin
                        ev_reg      <= wat_pkg::EV_RESEND;
                        slot_reg    <= wat_pkg::to_slot_field(scan_slot);
                        pkt_reg     <= base_reg + wat_pkg::NUM_W'(scan_slot);
                        last_reg    <= !higher_open;
                        if (!higher_open) begin
                            st_reg <= B_IDLE;
                        end else begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    st_reg <= B_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_marks_never_full: assert property (@(posedge aclk) disable iff (!aresetn)
        marks_reg != wat_pkg::FULL_MASK)
        else $error("all slot marks held set");

    a_done_after_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == B_DONE) |-> (marks_reg == '0))
        else $error("window complete pending with marks still set");

    a_pop_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (st_reg == B_CHECK || st_reg == B_SCAN))
        else $error("popped word not taken up");

    a_complete_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && ev_reg == wat_pkg::EV_COMPLETE) |-> last_reg)
        else $error("window complete word not marked last");
`endif

endmodule

@@ src/window_ack_tracker.sv @@
// window_ack_tracker: acknowledgement tracker for a five-packet window
// the front takes no new word while the 8-step remainder unit works or while its last word waits for the queue
// a timeout runs the back-end scan, which visits the slots one at a time, up to five
// reset: aresetn synchronous active low clears marks, base, stored numbers and queue
// depends on wat_pkg, wat_front, wat_queue, wat_back

module window_ack_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // ack_number[30:0], zero pad
    input  logic [0:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // event_res[1:0], slot[4:2], packet_number[35:5], zero pad
    output logic        m_tlast
);

    logic            push;
    logic            full;
    logic            pop;
    logic            empty;
    wat_pkg::entry_t push_data;
    wat_pkg::entry_t pop_data;

    wat_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (wat_pkg::kind_t'(s_tuser[0])),
        .in_num    (s_tdata[wat_pkg::NUM_W-1:0]),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    wat_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    wat_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .empty     (empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
